FILE: design/ksg_pkg.sv
// shared types, constants and lookup tables of the knob-set square generator
// used by ksg_lane, ksg_merge and the top level; depends on nothing
package ksg_pkg;

  localparam int unsigned KsgChannels = 4;
  localparam int unsigned KsgLevels   = 16;
  localparam int unsigned KsgReported = 4;   // channels carried in a transaction

  localparam int unsigned LevelW = 10;
  localparam int unsigned StepW  = 4;
  localparam int unsigned HalfW  = 15;
  localparam int unsigned CountW = 16;
  localparam int unsigned HzW    = 15;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdKnob = 1'b1;

  // upper bound of each knob range
  localparam logic [LevelW-1:0] KsgThresh [16] = '{
    10'd85,  10'd170, 10'd256, 10'd341, 10'd426, 10'd512, 10'd597, 10'd682,
    10'd725, 10'd768, 10'd810, 10'd853, 10'd896, 10'd938, 10'd981, 10'd1023
  };

  // half-period in ticks for each range, zero keeps the channel idle
  localparam logic [HalfW-1:0] KsgPeriod [16] = '{
    15'd0,   15'd31250, 15'd15625, 15'd7102, 15'd3397, 15'd1645, 15'd772, 15'd368,
    15'd176, 15'd84,    15'd40,    15'd19,   15'd9,    15'd4,    15'd2,   15'd1
  };

  // frequency shown on the display for each range
  localparam logic [HzW-1:0] KsgFreq [16] = '{
    15'd0,   15'd1,   15'd2,   15'd4,    15'd9,    15'd19,    15'd40,    15'd85,
    15'd178, 15'd372, 15'd781, 15'd1645, 15'd3472, 15'd7813, 15'd15625, 15'd31250
  };

  typedef struct packed {
    logic              cmd;
    logic [LevelW-1:0] level_a;
    logic [LevelW-1:0] level_b;
    logic [LevelW-1:0] level_c;
    logic [LevelW-1:0] level_d;
  } ksg_in_t;

  typedef struct packed {
    logic [3:0]       pins;
    logic             changed;
    logic [StepW-1:0] step_a;
    logic [StepW-1:0] step_b;
    logic [StepW-1:0] step_c;
    logic [StepW-1:0] step_d;
    logic [HzW-1:0]   hz_a;
    logic [HzW-1:0]   hz_b;
    logic [HzW-1:0]   hz_c;
    logic [HzW-1:0]   hz_d;
  } ksg_out_t;

  // what a lane reports to the merge stage
  typedef struct packed {
    logic             differs;   // selected half-period differs from current one
    logic [StepW-1:0] step;
    logic             pin_nx;    // pin level after this transaction
  } ksg_lane_stat_t;

  // what the merge stage tells a lane
  typedef struct packed {
    logic en;      // transaction accepted this cycle
    logic tick;
    logic load;    // take the new half-period
    logic clear;   // clear counter and pin
  } ksg_lane_ctl_t;

endpackage

FILE: design/ksg_lane.sv
// one divider channel: knob quantizer, half-period register, tick counter, pin
// depends on ksg_pkg
module ksg_lane #(
  parameter int unsigned Levels = ksg_pkg::KsgLevels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ksg_pkg::LevelW-1:0]    level_i,
  input  ksg_pkg::ksg_lane_ctl_t        ctl_i,
  output ksg_pkg::ksg_lane_stat_t       stat_o
);
  import ksg_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [HalfW-1:0]  half_q, half_d, half_new;
  logic              pin_q, pin_d;
  logic [StepW-1:0]  step;
  logic              hit;

  // first range whose bound the reading does not exceed
  always_comb begin
    step = StepW'(Levels - 1);
    for (int i = int'(Levels) - 1; i >= 0; i--) begin
      if (level_i <= KsgThresh[i]) begin
        step = StepW'(i);
      end
    end
  end

  assign half_new = KsgPeriod[step];
  assign cnt_inc  = cnt_q + CountW'(1);
  assign hit      = (half_q != '0) && (cnt_inc == {1'b0, half_q});

  always_comb begin
    cnt_d  = cnt_q;
    half_d = half_q;
    pin_d  = pin_q;
    if (ctl_i.tick) begin
      cnt_d = hit ? '0 : cnt_inc;
      pin_d = pin_q ^ hit;
    end else begin
      if (ctl_i.load) begin
        half_d = half_new;
      end
      if (ctl_i.clear) begin
        cnt_d = '0;
        pin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      half_q <= '0;
      pin_q  <= 1'b0;
    end else if (ctl_i.en) begin
      cnt_q  <= cnt_d;
      half_q <= half_d;
      pin_q  <= pin_d;
    end
  end

  assign stat_o.differs = (half_new != half_q);
  assign stat_o.step    = step;
  assign stat_o.pin_nx  = pin_d;

endmodule

FILE: design/ksg_merge.sv
// merge stage: picks the first channel to update and assembles the result
// depends on ksg_pkg
module ksg_merge #(
  parameter int unsigned Channels = ksg_pkg::KsgChannels
) (
  input  logic                    acc_i,
  input  logic                    cmd_i,
  input  ksg_pkg::ksg_lane_stat_t stat_i [Channels],
  output ksg_pkg::ksg_lane_ctl_t  ctl_o  [Channels],
  output ksg_pkg::ksg_out_t       res_o
);
  import ksg_pkg::*;

  localparam int unsigned RepN = (Channels < KsgReported) ? Channels : KsgReported;

  logic             found;
  logic             changed;
  logic [3:0]       pins;
  logic [StepW-1:0] steps [KsgReported];
  logic [HzW-1:0]   hz    [KsgReported];

  always_comb begin
    found = 1'b0;
    for (int c = 0; c < int'(Channels); c++) begin
      ctl_o[c].en   = acc_i;
      ctl_o[c].tick = (cmd_i == CmdTick);
      ctl_o[c].load = (cmd_i == CmdKnob) && stat_i[c].differs && !found;
      found         = found | stat_i[c].differs;
    end
    changed = (cmd_i == CmdKnob) && found;
    for (int c = 0; c < int'(Channels); c++) begin
      ctl_o[c].clear = changed;
    end
  end

  always_comb begin
    pins = '0;
    for (int c = 0; c < int'(KsgReported); c++) begin
      steps[c] = '0;
      hz[c]    = '0;
    end
    for (int c = 0; c < int'(RepN); c++) begin
      pins[c] = stat_i[c].pin_nx;
      if (cmd_i == CmdKnob) begin
        steps[c] = stat_i[c].step;
        hz[c]    = changed ? KsgFreq[stat_i[c].step] : '0;
      end
    end
  end

  assign res_o.pins    = pins;
  assign res_o.changed = changed;
  assign res_o.step_a  = steps[0];
  assign res_o.step_b  = steps[1];
  assign res_o.step_c  = steps[2];
  assign res_o.step_d  = steps[3];
  assign res_o.hz_a    = hz[0];
  assign res_o.hz_b    = hz[1];
  assign res_o.hz_c    = hz[2];
  assign res_o.hz_d    = hz[3];

endmodule

FILE: design/knob_set_four_channel_square_generator.sv
// top level of the knob-set square generator: lanes, merge stage, output skid
// depends on ksg_pkg, ksg_lane and ksg_merge
//
// Each input transaction gives exactly one result transaction. A tick transaction
// (cmd = 0) advances every channel counter; a channel with a nonzero half-period
// toggles its pin and restarts when the counter reaches it. A knob transaction
// (cmd = 1) quantizes four 10-bit readings into 16 ranges, and the first channel
// (A to D) whose range selects a new half-period takes it; if one does, all
// counters and pins clear and the display frequencies are reported. The block
// takes one transaction every cycle while in_stall_o is low: every channel is
// its own lane with a single 16-bit increment and compare, and the update
// decision is one priority pass over the lanes, so the result is registered as
// it is accepted. An output register backed by a one-entry skid stage lets input
// keep flowing while a result waits; in_stall_o rises only when both are full.
module knob_set_four_channel_square_generator #(
  parameter int unsigned Channels = ksg_pkg::KsgChannels,
  parameter int unsigned Levels   = ksg_pkg::KsgLevels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ksg_pkg::ksg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ksg_pkg::ksg_out_t out_data_o
);
  import ksg_pkg::*;

  logic           in_acc;
  logic           out_take;
  logic           out_vld_q, out_vld_d;
  logic           skid_vld_q, skid_vld_d;
  ksg_out_t       out_data_q;
  ksg_out_t       skid_data_q;
  ksg_out_t       res;

  logic [LevelW-1:0] lv [KsgReported];
  ksg_lane_stat_t    stat [Channels];
  ksg_lane_ctl_t     ctl  [Channels];

  // readings in channel order
  assign lv[0] = in_data_i.level_a;
  assign lv[1] = in_data_i.level_b;
  assign lv[2] = in_data_i.level_c;
  assign lv[3] = in_data_i.level_d;

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;

  // one lane per channel, channels past D read as zero
  for (genvar c = 0; c < int'(Channels); c++) begin : g_lane
    logic [LevelW-1:0] lane_level;
    if (c < int'(KsgReported)) begin : g_rd
      assign lane_level = lv[c];
    end else begin : g_zero
      assign lane_level = '0;
    end
    ksg_lane #(
      .Levels (Levels)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .level_i (lane_level),
      .ctl_i   (ctl[c]),
      .stat_o  (stat[c])
    );
  end

  ksg_merge #(
    .Channels (Channels)
  ) u_merge (
    .acc_i  (in_acc),
    .cmd_i  (in_data_i.cmd),
    .stat_i (stat),
    .ctl_o  (ctl),
    .res_o  (res)
  );

  // output register plus skid entry
  always_comb begin
    out_vld_d  = in_acc || skid_vld_q || (out_vld_q && !out_take);
    skid_vld_d = skid_vld_q ? !out_take : (in_acc && out_vld_q && !out_take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!out_vld_q || out_take) begin
        out_data_q <= res;
      end else begin
        skid_data_q <= res;
      end
    end else if (out_take && skid_vld_q) begin
      out_data_q <= skid_data_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // the skid entry is only ever filled behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while output register empty");

  // a tick transaction never reports an update
  a_tick_no_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.cmd == CmdTick)) |-> !res.changed)
    else $error("tick transaction reported an update");

  // an update clears every reported pin
  a_change_clears_pins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.changed) |-> (res.pins == '0))
    else $error("update left a pin high");

  // a full output stage with no take keeps its result
  a_hold_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i && skid_vld_q) |=> (out_vld_q && skid_vld_q))
    else $error("stalled result dropped");

endmodule
